[hdl/bitmap_block_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Check that expr holds at every clock edge outside reset.
`define BBA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("bitmap allocator: invariant violated");

// Check that cons holds in the same cycle as ante.
`define BBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator: implication violated");

// Check that cons holds in the cycle after ante.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator: sequence violated");

`endif

[hdl/bba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int MAP_WORDS     = 32;
	localparam int WORD_BITS     = 32;
	localparam int TOTAL_ENTRIES = MAP_WORDS * WORD_BITS;

	localparam int CMD_W   = 3;
	localparam int ENTRY_W = 11;
	localparam int INDEX_W = 10;
	localparam int TOTAL_W = 11;

	localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PTR_W  = $clog2(MAP_WORDS + 1);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int PAD_W  = 2 ** BIT_W;
	localparam int CNT_W  = $clog2(TOTAL_ENTRIES + 1);
	localparam int IDXF_W = ($clog2(TOTAL_ENTRIES) + 1 > INDEX_W) ?
		$clog2(TOTAL_ENTRIES) + 1 : INDEX_W;
	localparam int TOTAL_MAX = 2 ** TOTAL_W - 1;

	// Reciprocal for the entry-to-word split: exact for every ENTRY_W-bit value.
	localparam int DIV_S  = ENTRY_W + BIT_W;
	localparam int DIV_M  = (2 ** DIV_S + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W = ENTRY_W + DIV_S + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TEST  = 3'd0,
		CMD_SET   = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_COUNT = 3'd3,
		CMD_ALLOC = 3'd4
	} cmd_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_W-1:0]    rd_addr;
		logic                 wr_en;
		logic [ADDR_W-1:0]    wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} map_req_t;

	// Position, counted from the MSB, of the first zero bit of a word.
	function automatic logic [BIT_W-1:0] first_free(input logic [WORD_BITS-1:0] w);
		logic [PAD_W-1:0] vec;
		logic [BIT_W-1:0] idx;
		vec = '0;
		idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			vec[j] = ~w[WORD_BITS-1-j];
		end
		// Halve the window: step past the lower half when it holds no free bit.
		for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
			if ((vec & ~({PAD_W{1'b1}} << (1 << lvl))) == '0) begin
				idx[lvl] = 1'b1;
				vec      = vec >> (1 << lvl);
			end
		end
		return idx;
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_total(input logic [CNT_W-1:0] cnt);
		logic [TOTAL_W-1:0] res;
		if (32'(cnt) > 32'(TOTAL_MAX)) begin
			res = TOTAL_W'(TOTAL_MAX);
		end else begin
			res = TOTAL_W'(cnt);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[hdl/bba_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::CMD_W-1:0]   cmd;
	logic [bba_pkg::ENTRY_W-1:0] entry_number;

	modport source (output valid, output cmd, output entry_number, input ready);
	modport sink (input valid, input cmd, input entry_number, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        entry_used;
	logic                        alloc_ok;
	logic [bba_pkg::INDEX_W-1:0] alloc_index;
	logic [bba_pkg::TOTAL_W-1:0] used_total;

	modport source (output valid, output entry_used, output alloc_ok, output alloc_index,
		output used_total, input ready);
	modport sink (input valid, input entry_used, input alloc_ok, input alloc_index,
		input used_total, output ready);
endinterface

`default_nettype wire

[hdl/bba_map_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module bba_map_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::map_req_t             req,
	output logic [bba_pkg::WORD_BITS-1:0] rdata
);

	logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0] vld_q;
	logic [bba_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// A word never written since reset reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_q <= vld_q[req.rd_addr] ? mem[req.rd_addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/bitmap_block_allocator.sv]
// Path from accept to result valid: test and mark go through LOOK and MODIFY;
// count, invalid entries and unknown commands through FIN; allocate scans in SCAN,
// then goes through ALLOC, or FIN when the map is full. Each path waits in its last
// state until the result slot is free. The next item is taken in the cycle after
// its result is loaded, so a new item is never taken before the last is done; the
// scan reads one map word per cycle through the single read port of the map memory.
// Reset clears the used counter; per-word flags make the whole map read free.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator (
	input  logic     clk,
	input  logic     arst_n,
	bba_req_if.sink  req,
	bba_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MODIFY,
		ST_SCAN,
		ST_ALLOC,
		ST_FIN
	} state_t;

	state_t                            state_q;
	logic [bba_pkg::CMD_W-1:0]         cmd_q;
	logic [bba_pkg::ENTRY_W-1:0]       z_q;
	logic [bba_pkg::ADDR_W-1:0]        word_q;
	logic [bba_pkg::BIT_W-1:0]         pos_q;
	logic [bba_pkg::PTR_W-1:0]         ptr_q;
	logic [bba_pkg::ADDR_W-1:0]        chk_q;
	logic                              have_q;
	logic [bba_pkg::CNT_W-1:0]         cnt_q;
	logic                              rsp_valid_q;
	logic                              used_q;
	logic                              ok_q;
	logic [bba_pkg::INDEX_W-1:0]       index_q;
	logic [bba_pkg::TOTAL_W-1:0]       total_q;

	bba_pkg::map_req_t                 mem_req;
	logic [bba_pkg::WORD_BITS-1:0]     rdata;

	logic                              accept;
	logic                              out_free;
	logic                              rsp_load;
	logic                              ent_ok;
	logic [bba_pkg::ENTRY_W-1:0]       z_in;
	logic [bba_pkg::PROD_W-1:0]        prod;
	logic [bba_pkg::ENTRY_W-1:0]       base;
	logic [bba_pkg::WORD_BITS-1:0]     msb;
	logic [bba_pkg::WORD_BITS-1:0]     mask;
	logic [bba_pkg::WORD_BITS-1:0]     ff_mask;
	logic                              hit;
	logic                              full;
	logic [bba_pkg::BIT_W-1:0]         ff;
	logic [bba_pkg::IDXF_W-1:0]        idx_full;
	logic                              scan_found;
	logic                              scan_end;
	logic [bba_pkg::CNT_W-1:0]         cnt_d;

	bba_map_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign rsp_load = (state_q inside {ST_MODIFY, ST_ALLOC, ST_FIN}) && out_free;

	// Entry decode: zero-based entry, then its word by reciprocal multiply.
	assign ent_ok = (req.entry_number != '0) &&
		(32'(req.entry_number) <= 32'(bba_pkg::TOTAL_ENTRIES));
	assign z_in   = req.entry_number - bba_pkg::ENTRY_W'(1);
	assign prod   = bba_pkg::PROD_W'(z_in) * bba_pkg::PROD_W'(bba_pkg::DIV_M);
	assign base   = bba_pkg::ENTRY_W'(bba_pkg::ENTRY_W'(word_q) *
		bba_pkg::ENTRY_W'(bba_pkg::WORD_BITS));

	assign msb     = {1'b1, {(bba_pkg::WORD_BITS-1){1'b0}}};
	assign mask    = msb >> pos_q;
	assign hit     = |(rdata & mask);
	assign full    = &rdata;
	assign ff      = bba_pkg::first_free(rdata);
	assign ff_mask = msb >> ff;
	assign idx_full = bba_pkg::IDXF_W'(chk_q) * bba_pkg::IDXF_W'(bba_pkg::WORD_BITS) +
		bba_pkg::IDXF_W'(ff);

	assign scan_found = have_q && !full;
	assign scan_end   = ptr_q == bba_pkg::PTR_W'(bba_pkg::MAP_WORDS);

	always_comb begin
		mem_req = '0;
		cnt_d   = cnt_q;
		case (state_q)
			ST_LOOK: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = word_q;
			end
			ST_SCAN: begin
				mem_req.rd_en   = !scan_found && !scan_end;
				mem_req.rd_addr = bba_pkg::ADDR_W'(ptr_q);
			end
			ST_MODIFY: begin
				mem_req.wr_addr = word_q;
				if (cmd_q == bba_pkg::CMD_SET) begin
					mem_req.wr_en   = out_free && !hit;
					mem_req.wr_data = rdata | mask;
					if (!hit) begin
						cnt_d = cnt_q + bba_pkg::CNT_W'(1);
					end
				end else if (cmd_q == bba_pkg::CMD_CLEAR) begin
					mem_req.wr_en   = out_free && hit;
					mem_req.wr_data = rdata & ~mask;
					if (hit) begin
						cnt_d = cnt_q - bba_pkg::CNT_W'(1);
					end
				end
			end
			ST_ALLOC: begin
				mem_req.wr_en   = out_free;
				mem_req.wr_addr = chk_q;
				mem_req.wr_data = rdata | ff_mask;
				cnt_d           = cnt_q + bba_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			have_q      <= 1'b0;
			ptr_q       <= '0;
			req.ready   <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req.ready <= 1'b0;
						cmd_q     <= req.cmd;
						z_q       <= z_in;
						word_q    <= bba_pkg::ADDR_W'(prod >> bba_pkg::DIV_S);
						ptr_q     <= '0;
						have_q    <= 1'b0;
						if (req.cmd == bba_pkg::CMD_ALLOC) begin
							state_q <= ST_SCAN;
						end else if (ent_ok && (req.cmd inside {bba_pkg::CMD_TEST,
							bba_pkg::CMD_SET, bba_pkg::CMD_CLEAR})) begin
							state_q <= ST_LOOK;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						req.ready <= 1'b1;
					end
				end
				ST_LOOK: begin
					pos_q   <= bba_pkg::BIT_W'(z_q - base);
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					// Hold the read word until the result slot frees up.
					if (out_free) begin
						cnt_q       <= cnt_d;
						used_q      <= (cmd_q == bba_pkg::CMD_TEST) && hit;
						ok_q        <= 1'b0;
						index_q     <= '0;
						total_q     <= bba_pkg::sat_total(cnt_d);
						state_q     <= ST_IDLE;
						req.ready   <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_found) begin
						state_q <= ST_ALLOC;
					end else if (scan_end) begin
						state_q <= ST_FIN;
					end else begin
						chk_q  <= bba_pkg::ADDR_W'(ptr_q);
						ptr_q  <= ptr_q + bba_pkg::PTR_W'(1);
						have_q <= 1'b1;
					end
				end
				ST_ALLOC: begin
					if (out_free) begin
						cnt_q       <= cnt_d;
						used_q      <= 1'b0;
						ok_q        <= 1'b1;
						index_q     <= idx_full[bba_pkg::INDEX_W-1:0];
						total_q     <= bba_pkg::sat_total(cnt_d);
						state_q     <= ST_IDLE;
						req.ready   <= 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						used_q      <= 1'b0;
						ok_q        <= 1'b0;
						index_q     <= '0;
						total_q     <= bba_pkg::sat_total(cnt_q);
						state_q     <= ST_IDLE;
						req.ready   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_used  = used_q;
	assign rsp.alloc_ok    = ok_q;
	assign rsp.alloc_index = index_q;
	assign rsp.used_total  = total_q;

	`BBA_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, 32'(cnt_q) <= 32'(bba_pkg::TOTAL_ENTRIES))
	`BBA_ASSERT_ALWAYS(a_no_rd_wr, clk, arst_n, !(mem_req.rd_en && mem_req.wr_en))
	`BBA_ASSERT_IMPLY(a_wr_slot, clk, arst_n, mem_req.wr_en, out_free)
	`BBA_ASSERT_NEXT(a_alloc_cnt, clk, arst_n, state_q == ST_ALLOC && out_free,
		cnt_q == $past(cnt_q) + bba_pkg::CNT_W'(1))
	`BBA_ASSERT_IMPLY(a_scan_word, clk, arst_n, state_q == ST_SCAN && have_q,
		32'(chk_q) + 32'd1 == 32'(ptr_q))

endmodule

`default_nettype wire

[dv/tb_bitmap_block_allocator.sv]
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
	import bba_pkg::*;

	localparam int ENTRY_MAX      = 2 ** ENTRY_W - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = MAP_WORDS + 8;

	localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

	typedef struct packed {
		logic               entry_used;
		logic               alloc_ok;
		logic [INDEX_W-1:0] alloc_index;
		logic [TOTAL_W-1:0] used_total;
	} rsp_t;

	class alloc_scoreboard;
		logic [WORD_BITS-1:0] usage [MAP_WORDS];
		int unsigned          used_cnt;
		rsp_t                 pending_q [$];
		int unsigned          errors;
		int unsigned          checked;
		int unsigned          requests;
		int unsigned          per_cmd [8];
		int unsigned          allocs_taken;
		int unsigned          allocs_refused;
		int unsigned          invalid_ops;
		int unsigned          peak_used;

		function new();
			foreach (usage[i]) usage[i] = '0;
			foreach (per_cmd[i]) per_cmd[i] = 0;
			used_cnt       = 0;
			errors         = 0;
			checked        = 0;
			requests       = 0;
			allocs_taken   = 0;
			allocs_refused = 0;
			invalid_ops    = 0;
			peak_used      = 0;
		endfunction

		function int unsigned outstanding();
			return pending_q.size();
		endfunction

		// Apply one accepted request to the local map and queue its response.
		function void note_request(logic [CMD_W-1:0] c, logic [ENTRY_W-1:0] e);
			rsp_t        r;
			bit          in_map;
			bit          found;
			int unsigned z;
			int unsigned wi;
			int unsigned bp;
			r      = '0;
			found  = 1'b0;
			wi     = 0;
			bp     = 0;
			in_map = (e >= 1) && (e <= TOTAL_ENTRIES);
			if (in_map) begin
				z  = int'(e) - 1;
				wi = z / WORD_BITS;
				bp = WORD_BITS - 1 - (z % WORD_BITS);
			end
			requests++;
			per_cmd[c]++;
			case (c)
				CMD_TEST: begin
					if (in_map) r.entry_used = usage[wi][bp];
				end
				CMD_SET: begin
					if (in_map && !usage[wi][bp]) begin
						usage[wi][bp] = 1'b1;
						used_cnt++;
					end
				end
				CMD_CLEAR: begin
					if (in_map && usage[wi][bp]) begin
						usage[wi][bp] = 1'b0;
						used_cnt--;
					end
				end
				CMD_ALLOC: begin
					// take the lowest free entry, MSB of word 0 first
					for (int w = 0; w < MAP_WORDS && !found; w++) begin
						for (int j = 0; j < WORD_BITS && !found; j++) begin
							if (!usage[w][WORD_BITS-1-j]) begin
								usage[w][WORD_BITS-1-j] = 1'b1;
								used_cnt++;
								found         = 1'b1;
								r.alloc_ok    = 1'b1;
								r.alloc_index = INDEX_W'(w * WORD_BITS + j);
							end
						end
					end
					if (found) allocs_taken++;
					else allocs_refused++;
				end
				default: ;
			endcase
			if (c <= CMD_CLEAR && !in_map) invalid_ops++;
			if (used_cnt > peak_used) peak_used = used_cnt;
			r.used_total = (used_cnt > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(used_cnt);
			pending_q.push_back(r);
		endfunction

		function void report(string what, rsp_t want, rsp_t got);
			errors++;
			if (errors <= 10) begin
				$display("%t ERROR %s: want used=%0b ok=%0b idx=%0d total=%0d, got used=%0b ok=%0b idx=%0d total=%0d",
					$realtime, what, want.entry_used, want.alloc_ok, want.alloc_index,
					want.used_total, got.entry_used, got.alloc_ok, got.alloc_index,
					got.used_total);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_q.size() == 0) begin
				report("response with no request pending", '0, got);
			end else begin
				want = pending_q.pop_front();
				checked++;
				if (got.entry_used !== want.entry_used) report("entry_used", want, got);
				else if (got.alloc_ok !== want.alloc_ok) report("alloc_ok", want, got);
				else if (got.alloc_index !== want.alloc_index) report("alloc_index", want, got);
				else if (got.used_total !== want.used_total) report("used_total", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	bitmap_block_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	alloc_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned rx_mode    = 0;
	int unsigned rx_left    = 0;
	int unsigned rx_cyc     = 0;
	int unsigned idle_run   = 0;
	rsp_t        rx_got;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: check each accepted item, then pick ready from the current stall mode.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rx_got = '{rsp_ch.entry_used, rsp_ch.alloc_ok, rsp_ch.alloc_index, rsp_ch.used_total};
			sb.check_response(rx_got);
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end else begin
			rx_left--;
		end
		rx_cyc++;
		case (rx_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			2: rsp_ch.ready <= (rx_cyc % 4 == 0);
			default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_run = 0;
		end else begin
			idle_run++;
		end
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("%t watchdog: no item moved for %0d cycles, %0d responses pending",
				$realtime, idle_run, sb.outstanding());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one item and hold it until accepted; open a new burst with a random gap.
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [ENTRY_W-1:0] e);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= c;
		req_ch.entry_number <= e;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(c, e);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic logic [ENTRY_W-1:0] pick_entry();
		int unsigned r;
		logic [ENTRY_W-1:0] e;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			e = '0;
		end else if (r < 9) begin
			e = ENTRY_W'($urandom_range(TOTAL_ENTRIES + 1, ENTRY_MAX));
		end else if (r < 15) begin
			case ($urandom_range(0, 3))
				0: e = ENTRY_W'(1);
				1: e = ENTRY_W'(WORD_BITS);
				2: e = ENTRY_W'(WORD_BITS + 1);
				default: e = ENTRY_W'(TOTAL_ENTRIES);
			endcase
		end else begin
			e = ENTRY_W'($urandom_range(1, TOTAL_ENTRIES));
		end
		return e;
	endfunction

	// Mixed traffic; the drain flavor leans on mark free to open holes in a busy map.
	task automatic run_mix(input int unsigned n, input bit drain);
		int unsigned r;
		logic [CMD_W-1:0] c;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20) c = CMD_TEST;
			else if (r < 38) c = CMD_SET;
			else if (r < (drain ? 72 : 56)) c = CMD_CLEAR;
			else if (r < (drain ? 78 : 64)) c = CMD_COUNT;
			else if (r < (drain ? 94 : 92)) c = CMD_ALLOC;
			else c = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
			if (c <= CMD_CLEAR) send_item(c, pick_entry());
			else send_item(c, ENTRY_W'($urandom_range(0, ENTRY_MAX)));
		end
	endtask

	// Run the map up to full, mostly through allocate, partly through random marks.
	task automatic fill_map();
		int unsigned r;
		while (sb.used_cnt < TOTAL_ENTRIES) begin
			r = $urandom_range(0, 99);
			if (r < 65) send_item(CMD_ALLOC, ENTRY_W'($urandom_range(0, ENTRY_MAX)));
			else if (r < 90) send_item(CMD_SET, ENTRY_W'($urandom_range(1, TOTAL_ENTRIES)));
			else if (r < 95) send_item(CMD_TEST, pick_entry());
			else send_item(CMD_COUNT, ENTRY_W'($urandom_range(0, ENTRY_MAX)));
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.cmd          <= '0;
		req_ch.entry_number <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_TEST, ENTRY_W'(1));
		send_item(CMD_SET, ENTRY_W'(1));
		send_item(CMD_TEST, ENTRY_W'(1));
		send_item(CMD_SET, ENTRY_W'(1));
		send_item(CMD_SET, ENTRY_W'(TOTAL_ENTRIES));
		send_item(CMD_TEST, ENTRY_W'(TOTAL_ENTRIES));
		send_item(CMD_SET, ENTRY_W'(0));
		send_item(CMD_TEST, ENTRY_W'(0));
		send_item(CMD_SET, ENTRY_W'(TOTAL_ENTRIES + 1));
		send_item(CMD_TEST, ENTRY_W'(ENTRY_MAX));
		send_item(CMD_CLEAR, ENTRY_W'(ENTRY_MAX));
		send_item(CMD_COUNT, ENTRY_W'(ENTRY_MAX));
		send_item(CMD_ALLOC, ENTRY_W'(0));
		send_item(CMD_CLEAR, ENTRY_W'(1));
		send_item(CMD_CLEAR, ENTRY_W'(1));
		send_item(CMD_ALLOC, ENTRY_W'(ENTRY_MAX));
		send_item(CMD_RSVD_LO, ENTRY_W'(5));
		send_item(CMD_W'(6), ENTRY_W'(ENTRY_MAX));
		send_item(CMD_RSVD_HI, ENTRY_W'(1));
		send_item(CMD_SET, ENTRY_W'(WORD_BITS));
		send_item(CMD_SET, ENTRY_W'(WORD_BITS + 1));
		send_item(CMD_TEST, ENTRY_W'(WORD_BITS + 1));
		send_item(CMD_CLEAR, ENTRY_W'(TOTAL_ENTRIES));
		send_item(CMD_COUNT, ENTRY_W'(0));
		wait_idle();

		run_mix(200, 1'b0);
		fill_map();
		// hold the sender until the full map has settled
		wait_idle();
		for (int i = 0; i < 4; i++) send_item(CMD_ALLOC, ENTRY_W'($urandom_range(0, ENTRY_MAX)));
		send_item(CMD_SET, ENTRY_W'(1));
		send_item(CMD_TEST, ENTRY_W'(TOTAL_ENTRIES));
		send_item(CMD_COUNT, ENTRY_W'(0));
		for (int i = 0; i < 8; i++) send_item(CMD_CLEAR, ENTRY_W'($urandom_range(1, TOTAL_ENTRIES)));
		for (int i = 0; i < 10; i++) send_item(CMD_ALLOC, ENTRY_W'($urandom_range(0, ENTRY_MAX)));
		run_mix(150, 1'b1);
		run_mix(150, 1'b0);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d requests, %0d responses checked: test %0d, mark used %0d",
			sb.requests, sb.checked, sb.per_cmd[CMD_TEST], sb.per_cmd[CMD_SET]);
		$display("mark free %0d, count %0d, allocate %0d, reserved %0d",
			sb.per_cmd[CMD_CLEAR], sb.per_cmd[CMD_COUNT], sb.per_cmd[CMD_ALLOC],
			sb.per_cmd[5] + sb.per_cmd[6] + sb.per_cmd[7]);
		$display("Allocations taken %0d, refused on a full map %0d, out-of-range entries %0d",
			sb.allocs_taken, sb.allocs_refused, sb.invalid_ops);
		$display("Peak usage %0d of %0d, mismatches %0d",
			sb.peak_used, TOTAL_ENTRIES, sb.errors);
		if (sb.outstanding() != 0) begin
			$display("%0d responses never arrived", sb.outstanding());
		end
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_map_store.sv
hdl/bitmap_block_allocator.sv
dv/tb_bitmap_block_allocator.sv
